/* hdl/scl_pkg.sv */
// Shared types, constants and the command letter decoder for the command line interpreter.
`default_nettype none

package scl_pkg;

	// Line length limit and channel range
	localparam int LINE_BYTES  = 128;
	localparam int MAX_CHANNEL = 14;
	localparam int CNT_W       = $clog2(LINE_BYTES);

	// Characters with a meaning of their own
	localparam logic [7:0] CHAR_CR   = 8'h0D;
	localparam logic [7:0] CHAR_LF   = 8'h0A;
	localparam logic [7:0] CHAR_ZERO = 8'h30;

	typedef enum logic [3:0] {
		ACT_NONE      = 4'd0,
		ACT_HOP_ON    = 4'd1,
		ACT_HOP_OFF   = 4'd2,
		ACT_TYPE_SET  = 4'd3,
		ACT_TYPE_CLR  = 4'd4,
		ACT_SD_ON     = 4'd5,
		ACT_SD_OFF    = 4'd6,
		ACT_SD_REINIT = 4'd7,
		ACT_FLUSH     = 4'd8,
		ACT_DROP_ON   = 4'd9,
		ACT_DROP_OFF  = 4'd10,
		ACT_SCAN      = 4'd11,
		ACT_SKIP_OFF  = 4'd12
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_LONG  = 2'd2
	} status_t;

	// A completed line, handed from the line assembler to the command stage
	typedef struct packed {
		logic        done;
		action_t     action;
		logic [31:0] arg;
		logic        bare;
		logic        overlong;
	} line_t;

	// Map a command letter to its action code
	function automatic action_t letter_code(input logic [7:0] c);
		action_t a;
		case (c)
			"S":     a = ACT_HOP_ON;
			"s":     a = ACT_HOP_OFF;
			"P":     a = ACT_TYPE_SET;
			"p":     a = ACT_TYPE_CLR;
			"W":     a = ACT_SD_ON;
			"w":     a = ACT_SD_OFF;
			"F":     a = ACT_SD_REINIT;
			"f":     a = ACT_FLUSH;
			"T":     a = ACT_DROP_ON;
			"t":     a = ACT_DROP_OFF;
			"B":     a = ACT_SCAN;
			"b":     a = ACT_SKIP_OFF;
			default: a = ACT_NONE;
		endcase
		return a;
	endfunction

endpackage

`default_nettype wire

/* hdl/serial_command_line_interpreter.sv */
// Serial command line interpreter: top level with input stage, command stage and result register.
//
// Usage:
//   Input channel rx_byte / in_valid / in_ready carries one received serial
//   word per transfer. A line is a command letter, argument digits and a CR
//   or LF terminator. Each terminator produces exactly one result word on
//   action ... beacon_scan_now / out_valid / out_ready; other words give none.
//   A terminator passes the input register, then the result register, before
//   its result is shown. Throughput: one word per cycle while the receiver
//   takes results, set by the single command stage that updates all settings.
//   Reset clears the line in progress, all settings go to their defaults
//   (channel 1, flush interval 1, everything else off) and no result is held.
//   While the receiver stalls, the result register holds its word and the
//   input register stalls behind it; in_ready drops once both are occupied.
`default_nettype none

module serial_command_line_interpreter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       action,
	output logic [1:0]       status,
	output logic [3:0]       channel,
	output logic             hopping_on,
	output logic [63:0]      type_mask,
	output logic             write_sd,
	output logic             drop_frames,
	output logic             skip_quiet,
	output logic [30:0]      flush_interval,
	output logic             sd_reinit,
	output logic             beacon_scan_now
);
	import scl_pkg::*;

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       step;
	line_t      line;

	// Settings
	logic [63:0] types_q;
	logic        sd_q;
	logic        drop_q;
	logic        skip_q;
	logic [30:0] flush_q;
	logic        hop_q;
	logic [3:0]  chan_q;

	logic [63:0] types_d;
	logic        sd_d;
	logic        drop_d;
	logic        skip_d;
	logic [30:0] flush_d;
	logic        hop_d;
	logic [3:0]  chan_d;
	status_t     status_d;
	logic        reinit_d;
	logic        scan_d;
	logic [63:0] bit_sel;

	// Result register
	logic        out_valid_q;
	logic [3:0]  action_q;
	logic [1:0]  status_q;
	logic [3:0]  chan_out_q;
	logic        hop_out_q;
	logic [63:0] types_out_q;
	logic        sd_out_q;
	logic        drop_out_q;
	logic        skip_out_q;
	logic [30:0] flush_out_q;
	logic        reinit_q;
	logic        scan_q;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	// Hold the accepted word until the command stage can take it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	scl_line u_line (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.line    (line)
	);

	assign bit_sel = 64'd1 << line.arg[5:0];

	// Run the command of a finished line
	always_comb begin
		types_d  = types_q;
		sd_d     = sd_q;
		drop_d   = drop_q;
		skip_d   = skip_q;
		flush_d  = flush_q;
		hop_d    = hop_q;
		chan_d   = chan_q;
		status_d = ST_OK;
		reinit_d = 1'b0;
		scan_d   = 1'b0;
		if (line.overlong) begin
			status_d = ST_LONG;
		end else begin
			case (line.action)
				ACT_HOP_ON: begin
					hop_d = 1'b1;
				end
				ACT_HOP_OFF: begin
					hop_d = 1'b0;
					if (line.arg >= 32'd1 && line.arg <= 32'(MAX_CHANNEL)) begin
						chan_d = line.arg[3:0];
					end else begin
						status_d = ST_RANGE;
					end
				end
				ACT_TYPE_SET: begin
					if (line.arg > 32'd63) begin
						status_d = ST_RANGE;
					end else begin
						types_d = types_q | bit_sel;
					end
				end
				ACT_TYPE_CLR: begin
					if (line.arg > 32'd63) begin
						status_d = ST_RANGE;
					end else begin
						types_d = types_q & ~bit_sel;
					end
				end
				ACT_SD_ON:     sd_d = 1'b1;
				ACT_SD_OFF:    sd_d = 1'b0;
				ACT_SD_REINIT: reinit_d = 1'b1;
				ACT_FLUSH: begin
					if (line.arg != 32'd0 && !line.arg[31]) begin
						flush_d = line.arg[30:0];
					end else begin
						status_d = ST_RANGE;
					end
				end
				ACT_DROP_ON:  drop_d = 1'b1;
				ACT_DROP_OFF: drop_d = 1'b0;
				ACT_SCAN: begin
					if (line.bare) begin
						scan_d = 1'b1;
						skip_d = 1'b1;
					end
				end
				ACT_SKIP_OFF: skip_d = 1'b0;
				default: begin
				end
			endcase
		end
	end

	// Commit settings at each finished line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			types_q <= '0;
			sd_q    <= 1'b0;
			drop_q  <= 1'b0;
			skip_q  <= 1'b0;
			flush_q <= 31'd1;
			hop_q   <= 1'b0;
			chan_q  <= 4'd1;
		end else if (step && line.done) begin
			types_q <= types_d;
			sd_q    <= sd_d;
			drop_q  <= drop_d;
			skip_q  <= skip_d;
			flush_q <= flush_d;
			hop_q   <= hop_d;
			chan_q  <= chan_d;
		end
	end

	// Load the result word, drop valid once it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && line.done;
		end
	end

	always_ff @(posedge clk) begin
		if (step && line.done) begin
			action_q    <= line.action;
			status_q    <= status_d;
			chan_out_q  <= chan_d;
			hop_out_q   <= hop_d;
			types_out_q <= types_d;
			sd_out_q    <= sd_d;
			drop_out_q  <= drop_d;
			skip_out_q  <= skip_d;
			flush_out_q <= flush_d;
			reinit_q    <= reinit_d;
			scan_q      <= scan_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign action          = action_q;
	assign status          = status_q;
	assign channel         = chan_out_q;
	assign hopping_on      = hop_out_q;
	assign type_mask       = types_out_q;
	assign write_sd        = sd_out_q;
	assign drop_frames     = drop_out_q;
	assign skip_quiet      = skip_out_q;
	assign flush_interval  = flush_out_q;
	assign sd_reinit       = reinit_q;
	assign beacon_scan_now = scan_q;

endmodule

`default_nettype wire

/* hdl/scl_line.sv */
// Line assembler: command letter, decimal argument, length count and overlong flag.
`default_nettype none

module scl_line (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [7:0]        rx_byte,
	output scl_pkg::line_t         line
);
	import scl_pkg::*;

	logic [7:0]       letter_q;
	logic [31:0]      arg_q;
	logic [CNT_W-1:0] cnt_q;
	logic             overlong_q;

	logic is_term;
	logic take;
	logic first;
	logic full;

	assign is_term = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);
	assign first   = (cnt_q == '0);
	assign take    = !is_term || first;
	assign full    = (cnt_q >= CNT_W'(LINE_BYTES - 1));

	// Report a finished line: a terminator, or a terminator as the first word
	always_comb begin
		line.done     = is_term && (first || !take);
		line.action   = first ? ACT_NONE : letter_code(letter_q);
		line.arg      = arg_q;
		line.bare     = (cnt_q == CNT_W'(1));
		line.overlong = overlong_q && !first;
	end

	// Collect words of the current line, drop them once it runs too long
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			letter_q   <= '0;
			arg_q      <= '0;
			cnt_q      <= '0;
			overlong_q <= 1'b0;
		end else if (step) begin
			if (line.done) begin
				letter_q   <= '0;
				arg_q      <= '0;
				cnt_q      <= '0;
				overlong_q <= 1'b0;
			end else if (take && !overlong_q) begin
				if (full) begin
					overlong_q <= 1'b1;
				end else begin
					if (first) begin
						letter_q <= rx_byte;
					end else begin
						arg_q <= (arg_q << 3) + (arg_q << 1) + {24'd0, rx_byte}
							- {24'd0, CHAR_ZERO};
					end
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/scl_chk.sv */
// Port checker for the command line interpreter and its bind to the top level.
`default_nettype none

module scl_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [3:0]  action,
	input wire logic [1:0]  status,
	input wire logic [3:0]  channel,
	input wire logic [63:0] type_mask,
	input wire logic        skip_quiet,
	input wire logic [30:0] flush_interval,
	input wire logic        sd_reinit,
	input wire logic        beacon_scan_now
);
	import scl_pkg::*;

	// Hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(action) && $stable(type_mask)
			&& $stable(status) && $stable(flush_interval))
		else $error("result word changed while stalled");

	// Keep channel and flush interval in range
	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> channel != 4'd0 && channel <= 4'(MAX_CHANNEL) && flush_interval != 31'd0)
		else $error("channel or flush interval out of range");

	// Pulse reinit only for its own command, never on a discarded line
	a_reinit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sd_reinit |-> action == 4'(ACT_SD_REINIT) && status == 2'(ST_OK))
		else $error("reinit pulse on wrong command");

	// A scan pulse comes from a bare scan command and turns skipping on
	a_scan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && beacon_scan_now |-> action == 4'(ACT_SCAN) && skip_quiet
			&& status == 2'(ST_OK))
		else $error("scan pulse inconsistent");

endmodule

bind serial_command_line_interpreter scl_chk u_scl_chk (.*);

`default_nettype wire

/* bench/serial_command_line_interpreter_tb.sv */
// Self-checking testbench for the serial command line interpreter: line stimulus, predictor, result checks.
`default_nettype none

import scl_pkg::*;

typedef struct packed {
	action_t     action;
	status_t     status;
	logic [3:0]  channel;
	logic        hopping_on;
	logic [63:0] type_mask;
	logic        write_sd;
	logic        drop_frames;
	logic        skip_quiet;
	logic [30:0] flush_interval;
	logic        sd_reinit;
	logic        beacon_scan_now;
} cli_result_t;

// Tracks the line being assembled and the settings, and holds the results still to come
class cli_checker;
	logic [7:0]  line_letter;
	logic [31:0] line_arg;
	int unsigned line_len;
	bit          line_dropped;

	logic [63:0] kept_mask;
	bit          sd_on;
	bit          drop_on;
	bit          skip_on;
	bit          hop_on;
	logic [3:0]  cur_channel;
	logic [30:0] flush_count;

	cli_result_t pending_results[$];
	int          errors;
	int          results_checked;
	int          overlong_lines;

	function new();
		start_line();
		kept_mask   = '0;
		sd_on       = 1'b0;
		drop_on     = 1'b0;
		skip_on     = 1'b0;
		hop_on      = 1'b0;
		cur_channel = 4'd1;
		flush_count = 31'd1;
		errors          = 0;
		results_checked = 0;
		overlong_lines  = 0;
	endfunction

	function void start_line();
		line_letter  = '0;
		line_arg     = '0;
		line_len     = 0;
		line_dropped = 1'b0;
	endfunction

	function action_t decode_letter(logic [7:0] c);
		case (c)
			"S":     return ACT_HOP_ON;
			"s":     return ACT_HOP_OFF;
			"P":     return ACT_TYPE_SET;
			"p":     return ACT_TYPE_CLR;
			"W":     return ACT_SD_ON;
			"w":     return ACT_SD_OFF;
			"F":     return ACT_SD_REINIT;
			"f":     return ACT_FLUSH;
			"T":     return ACT_DROP_ON;
			"t":     return ACT_DROP_OFF;
			"B":     return ACT_SCAN;
			"b":     return ACT_SKIP_OFF;
			default: return ACT_NONE;
		endcase
	endfunction

	// Advance the line by one accepted word; a terminator runs the command
	function void take_word(logic [7:0] b);
		bit          is_term;
		cli_result_t r;
		is_term = (b == CHAR_CR) || (b == CHAR_LF);
		if (!is_term || line_len == 0) begin
			if (line_dropped)
				return;
			if (line_len >= LINE_BYTES - 1) begin
				line_dropped = 1'b1;
				return;
			end
			if (line_len == 0)
				line_letter = b;
			else
				line_arg = line_arg * 32'd10 + {24'd0, b} - {24'd0, CHAR_ZERO};
			line_len++;
			if (!(line_len == 1 && is_term))
				return;
		end

		r                 = '0;
		r.action          = decode_letter(line_letter);
		r.status          = ST_OK;
		if (line_dropped) begin
			r.status = ST_LONG;
			overlong_lines++;
		end else begin
			case (r.action)
				ACT_HOP_ON: hop_on = 1'b1;
				ACT_HOP_OFF: begin
					hop_on = 1'b0;
					if (line_arg >= 1 && line_arg <= MAX_CHANNEL)
						cur_channel = line_arg[3:0];
					else
						r.status = ST_RANGE;
				end
				ACT_TYPE_SET, ACT_TYPE_CLR: begin
					if (line_arg > 63)
						r.status = ST_RANGE;
					else
						kept_mask[line_arg[5:0]] = (r.action == ACT_TYPE_SET);
				end
				ACT_SD_ON:     sd_on = 1'b1;
				ACT_SD_OFF:    sd_on = 1'b0;
				ACT_SD_REINIT: r.sd_reinit = 1'b1;
				ACT_FLUSH: begin
					// the argument counts as signed: zero and negatives are refused
					if (line_arg != 0 && !line_arg[31])
						flush_count = line_arg[30:0];
					else
						r.status = ST_RANGE;
				end
				ACT_DROP_ON:  drop_on = 1'b1;
				ACT_DROP_OFF: drop_on = 1'b0;
				ACT_SCAN: begin
					// only a bare B scans; with argument words it changes nothing
					if (line_len == 1) begin
						r.beacon_scan_now = 1'b1;
						skip_on           = 1'b1;
					end
				end
				ACT_SKIP_OFF: skip_on = 1'b0;
				default: ;
			endcase
		end

		r.channel        = cur_channel;
		r.hopping_on     = hop_on;
		r.type_mask      = kept_mask;
		r.write_sd       = sd_on;
		r.drop_frames    = drop_on;
		r.skip_quiet     = skip_on;
		r.flush_interval = flush_count;
		pending_results.push_back(r);
		start_line();
	endfunction

	function void flag(string what, logic [63:0] want, logic [63:0] got);
		errors++;
		if (errors <= 10)
			$display("[%0t] %s: expected %0h, got %0h", $time, what, want, got);
	endfunction

	function void compare(string what, logic [63:0] want, logic [63:0] got);
		if (want !== got)
			flag(what, want, got);
	endfunction

	// Check one result word against the oldest expected one
	function void check_result(cli_result_t got);
		cli_result_t want;
		if (pending_results.size() == 0) begin
			flag("unexpected result word, action", '0, got.action);
			return;
		end
		want = pending_results.pop_front();
		results_checked++;
		compare("action",          want.action,          got.action);
		compare("status",          want.status,          got.status);
		compare("channel",         want.channel,         got.channel);
		compare("hopping_on",      want.hopping_on,      got.hopping_on);
		compare("type_mask",       want.type_mask,       got.type_mask);
		compare("write_sd",        want.write_sd,        got.write_sd);
		compare("drop_frames",     want.drop_frames,     got.drop_frames);
		compare("skip_quiet",      want.skip_quiet,      got.skip_quiet);
		compare("flush_interval",  want.flush_interval,  got.flush_interval);
		compare("sd_reinit",       want.sd_reinit,       got.sd_reinit);
		compare("beacon_scan_now", want.beacon_scan_now, got.beacon_scan_now);
	endfunction

	function void close_out();
		if (pending_results.size() != 0) begin
			errors += pending_results.size();
			$display("%0d expected result words never arrived", pending_results.size());
		end
	endfunction
endclass

module serial_command_line_interpreter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_WORDS = 1450;
	localparam int WATCHDOG     = 5000;
	localparam logic [7:0] CMD_LETTERS [12] =
		'{"S", "s", "P", "p", "W", "w", "F", "f", "T", "t", "B", "b"};

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte   = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [3:0]  action;
	logic [1:0]  status;
	logic [3:0]  channel;
	logic        hopping_on;
	logic [63:0] type_mask;
	logic        write_sd;
	logic        drop_frames;
	logic        skip_quiet;
	logic [30:0] flush_interval;
	logic        sd_reinit;
	logic        beacon_scan_now;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int words_sent     = 0;
	int ignored_words  = 0;
	int quiet_cycles   = 0;

	cli_checker board = new();

	serial_command_line_interpreter dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.rx_byte         (rx_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.action          (action),
		.status          (status),
		.channel         (channel),
		.hopping_on      (hopping_on),
		.type_mask       (type_mask),
		.write_sd        (write_sd),
		.drop_frames     (drop_frames),
		.skip_quiet      (skip_quiet),
		.flush_interval  (flush_interval),
		.sd_reinit       (sd_reinit),
		.beacon_scan_now (beacon_scan_now)
	);

	always #5 clk = ~clk;

	// Stall the receiver at random
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watch both channels, feed the predictor and check results
	always @(posedge clk) begin
		cli_result_t seen;
		if (arst_n) begin
			if (in_valid && in_ready)
				board.take_word(rx_byte);
			if (out_valid && out_ready) begin
				seen.action          = action_t'(action);
				seen.status          = status_t'(status);
				seen.channel         = channel;
				seen.hopping_on      = hopping_on;
				seen.type_mask       = type_mask;
				seen.write_sd        = write_sd;
				seen.drop_frames     = drop_frames;
				seen.skip_quiet      = skip_quiet;
				seen.flush_interval  = flush_interval;
				seen.sd_reinit       = sd_reinit;
				seen.beacon_scan_now = beacon_scan_now;
				board.check_result(seen);
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG) begin
			$display("watchdog: no word moved for %0d cycles", WATCHDOG);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Offer one word, with random idle cycles ahead of it, and hold it until taken
	task automatic send_word(input logic [7:0] b);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_word(s[i]);
	endtask

	task automatic send_number(input logic [31:0] v);
		logic [7:0]  digits[$];
		logic [31:0] rest;
		rest = v;
		do begin
			digits.push_front(CHAR_ZERO + 8'(rest % 10));
			rest = rest / 10;
		end while (rest != 0);
		foreach (digits[i])
			send_word(digits[i]);
	endtask

	function automatic logic [7:0] noise_word();
		logic [7:0] b;
		b = 8'($urandom_range(255));
		if (b == CHAR_CR || b == CHAR_LF)
			b = b ^ 8'h80;
		return b;
	endfunction

	// Send one line: mostly a known command, bare or with an argument, some noise or overlong runs
	task automatic send_line();
		logic [7:0]  letter;
		logic [31:0] arg;
		int          kind;
		int          pad;
		if ($urandom_range(99) < 85)
			letter = CMD_LETTERS[$urandom_range(11)];
		else
			letter = 8'($urandom_range(255));
		send_word(letter);
		// a terminator as the letter already ends the line
		if (letter == CHAR_CR || letter == CHAR_LF)
			return;
		kind = $urandom_range(99);
		if (kind < 25) begin
			// bare command
		end else if (kind < 60) begin
			case (letter)
				"s":      arg = $urandom_range(16);
				"P", "p": arg = $urandom_range(70);
				"f": begin
					case ($urandom_range(6))
						0:       arg = 32'd0;
						1:       arg = 32'd1;
						2:       arg = 32'h7FFF_FFFF;
						3:       arg = 32'h8000_0000;
						4:       arg = 32'hFFFF_FFFF;
						5:       arg = $urandom_range(1000);
						default: arg = $urandom;
					endcase
				end
				default:  arg = $urandom_range(999);
			endcase
			send_number(arg);
		end else if (kind < 80) begin
			send_number($urandom);
		end else if (kind < 97) begin
			repeat ($urandom_range(8, 1))
				send_word(noise_word());
		end else begin
			// run the line up to and past its length limit
			pad = LINE_BYTES - 3 + $urandom_range(3);
			if ($urandom_range(3) == 0)
				pad += $urandom_range(30);
			for (int j = 0; j < pad; j++) begin
				send_word($urandom_range(1) ? CHAR_ZERO + 8'($urandom_range(9)) : noise_word());
				if (j + 2 >= LINE_BYTES)
					ignored_words++;
			end
		end
		send_word($urandom_range(1) ? CHAR_CR : CHAR_LF);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed lines: empty line, every command, range limits, unknown letter
		send_text("\n");
		send_text("S\r");
		send_text("s14\n");
		send_text("s0\r");
		send_text("P63\n");
		send_text("p64\n");
		send_text("W\nw\rF\nT\nt\r");
		send_text("B\n");
		send_text("B7\n");
		send_text("b\n");
		send_text("f0\n");
		send_text("Z\r");

		// Random lines over four idling phases
		while (words_sent - ignored_words < RANDOM_WORDS) begin
			case ((words_sent - ignored_words) * 4 / RANDOM_WORDS)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
				default: begin send_idle_pct = 10; recv_stall_pct = 10; end
			endcase
			send_line();
		end
		send_text("\n");
		in_valid <= 1'b0;

		// Drain the results, then allow the pipeline latency to pass
		while (board.pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		board.close_out();

		$display("sent %0d words (%0d past the line limit), checked %0d result words",
			words_sent, ignored_words, board.results_checked);
		$display("overlong lines: %0d, mismatches: %0d", board.overlong_lines, board.errors);
		if (board.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

`default_nettype wire

/* serial_command_line_interpreter.f */
hdl/scl_pkg.sv
hdl/scl_line.sv
hdl/serial_command_line_interpreter.sv
hdl/scl_chk.sv
bench/serial_command_line_interpreter_tb.sv
